// ----- hw/rtl/mks_pkg.sv -----
`timescale 1ns / 1ps

package mks_pkg;

	localparam int CHAR_W = 8;
	localparam int TICK_W = 24;
	localparam int DUR_W  = 27;
	localparam int CODE_W = 7;
	localparam int LEN_W  = 3;
	localparam int UNIT_W = 3;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;

	localparam logic [TICK_W-1:0] TICKS_RESET = TICK_W'(1000);

	localparam logic [UNIT_W-1:0] UNITS_WORD = 3'd7;
	localparam logic [UNIT_W-1:0] UNITS_CHAR = 3'd3;
	localparam logic [UNIT_W-1:0] UNITS_DASH = 3'd3;
	localparam logic [UNIT_W-1:0] UNITS_DOT  = 3'd1;

	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;

	localparam logic REG_DOT     = 1'b0;
	localparam logic REG_SPACING = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_PRE,
		ST_ON,
		ST_GAP,
		ST_POST,
		ST_WORD
	} state_t;

	// pat is right aligned, first element in the highest used bit, dash = 1
	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] pat;
	} code_t;

	typedef struct packed {
		logic              accept;
		logic              load;
		logic              advance;
		logic              level;
		logic              spacing;
		logic [UNIT_W-1:0] units;
		logic              last;
	} cmd_t;

	typedef struct packed {
		logic word;
		logic pre;
		logic has_elem;
		logic final_elem;
		logic dash;
		logic msg_end;
		logic out_free;
	} st_t;

	function automatic code_t mks_rom(input logic [CHAR_W-1:0] ch);
		logic [CHAR_W-1:0] c;
		code_t r;
		c = ch;
		if (ch >= "a" && ch <= "z") begin
			c = ch - 8'd32;
		end
		r = '{3'd0, 7'd0};
		case (c)
			"A": r = '{3'd2, 7'(2'b01)};
			"B": r = '{3'd4, 7'(4'b1000)};
			"C": r = '{3'd4, 7'(4'b1010)};
			"D": r = '{3'd3, 7'(3'b100)};
			"E": r = '{3'd1, 7'(1'b0)};
			"F": r = '{3'd4, 7'(4'b0010)};
			"G": r = '{3'd3, 7'(3'b110)};
			"H": r = '{3'd4, 7'(4'b0000)};
			"I": r = '{3'd2, 7'(2'b00)};
			"J": r = '{3'd4, 7'(4'b0111)};
			"K": r = '{3'd3, 7'(3'b101)};
			"L": r = '{3'd4, 7'(4'b0100)};
			"M": r = '{3'd2, 7'(2'b11)};
			"N": r = '{3'd2, 7'(2'b10)};
			"O": r = '{3'd3, 7'(3'b111)};
			"P": r = '{3'd4, 7'(4'b0110)};
			"Q": r = '{3'd4, 7'(4'b1101)};
			"R": r = '{3'd3, 7'(3'b010)};
			"S": r = '{3'd3, 7'(3'b000)};
			"T": r = '{3'd1, 7'(1'b1)};
			"U": r = '{3'd3, 7'(3'b001)};
			"V": r = '{3'd4, 7'(4'b0001)};
			"W": r = '{3'd3, 7'(3'b011)};
			"X": r = '{3'd4, 7'(4'b1001)};
			"Y": r = '{3'd4, 7'(4'b1011)};
			"Z": r = '{3'd4, 7'(4'b1100)};
			"0": r = '{3'd5, 7'(5'b11111)};
			"1": r = '{3'd5, 7'(5'b01111)};
			"2": r = '{3'd5, 7'(5'b00111)};
			"3": r = '{3'd5, 7'(5'b00011)};
			"4": r = '{3'd5, 7'(5'b00001)};
			"5": r = '{3'd5, 7'(5'b00000)};
			"6": r = '{3'd5, 7'(5'b10000)};
			"7": r = '{3'd5, 7'(5'b11000)};
			"8": r = '{3'd5, 7'(5'b11100)};
			"9": r = '{3'd5, 7'(5'b11110)};
			".": r = '{3'd6, 7'(6'b010101)};
			",": r = '{3'd6, 7'(6'b110011)};
			"?": r = '{3'd6, 7'(6'b001100)};
			"'": r = '{3'd6, 7'(6'b011110)};
			"!": r = '{3'd6, 7'(6'b101011)};
			"/": r = '{3'd5, 7'(5'b10010)};
			"(": r = '{3'd5, 7'(5'b10110)};
			")": r = '{3'd6, 7'(6'b101101)};
			"&": r = '{3'd5, 7'(5'b01000)};
			":": r = '{3'd6, 7'(6'b111000)};
			";": r = '{3'd6, 7'(6'b101010)};
			"=": r = '{3'd5, 7'(5'b10001)};
			"+": r = '{3'd5, 7'(5'b01010)};
			"-": r = '{3'd6, 7'(6'b100001)};
			"_": r = '{3'd6, 7'(6'b001101)};
			"\"": r = '{3'd6, 7'(6'b010010)};
			"$": r = '{3'd7, 7'b0001001};
			"@": r = '{3'd6, 7'(6'b011010)};
			default: r = '{3'd0, 7'd0};
		endcase
		return r;
	endfunction

endpackage

// ----- hw/rtl/mks_regs.sv -----
`timescale 1ns / 1ps

module mks_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mks_pkg::ADDR_W-1:0]  paddr,
	input  logic [mks_pkg::DATA_W-1:0]  pwdata,
	output logic [mks_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output logic [mks_pkg::TICK_W-1:0]  dot_ticks,
	output logic [mks_pkg::TICK_W-1:0]  spacing_dot_ticks
);
	import mks_pkg::*;

	logic [TICK_W-1:0] dot_q;
	logic [TICK_W-1:0] spc_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= TICKS_RESET;
			spc_q <= TICKS_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_DOT:     dot_q <= pwdata[TICK_W-1:0];
				REG_SPACING: spc_q <= pwdata[TICK_W-1:0];
				default:     dot_q <= dot_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_DOT:     prdata = DATA_W'(dot_q);
			REG_SPACING: prdata = DATA_W'(spc_q);
			default:     prdata = '0;
		endcase
	end

	assign dot_ticks         = dot_q;
	assign spacing_dot_ticks = spc_q;

endmodule

// ----- hw/rtl/mks_ctrl.sv -----
`timescale 1ns / 1ps

module mks_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  mks_pkg::st_t  st,
	output mks_pkg::cmd_t cmd
);
	import mks_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		cmd         = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (st.word) begin
					state_d = ST_WORD;
				end else if (st.pre) begin
					state_d = ST_PRE;
				end else if (st.has_elem) begin
					state_d = ST_ON;
				end else if (st.msg_end) begin
					state_d = ST_POST;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_PRE: begin
				cmd.spacing = 1'b1;
				cmd.units   = UNITS_CHAR;
				cmd.last    = !st.has_elem && !st.msg_end;
				if (st.out_free) begin
					cmd.load = 1'b1;
					if (st.has_elem) begin
						state_d = ST_ON;
					end else if (st.msg_end) begin
						state_d = ST_POST;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_ON: begin
				cmd.level = 1'b1;
				cmd.units = st.dash ? UNITS_DASH : UNITS_DOT;
				cmd.last  = st.final_elem && !st.msg_end;
				if (st.out_free) begin
					cmd.load    = 1'b1;
					cmd.advance = 1'b1;
					if (!st.final_elem) begin
						state_d = ST_GAP;
					end else if (st.msg_end) begin
						state_d = ST_POST;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_GAP: begin
				cmd.units = UNITS_DOT;
				if (st.out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_ON;
				end
			end
			ST_POST: begin
				cmd.spacing = 1'b1;
				cmd.units   = UNITS_CHAR;
				cmd.last    = 1'b1;
				if (st.out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_WORD: begin
				cmd.spacing = 1'b1;
				cmd.units   = UNITS_WORD;
				cmd.last    = 1'b1;
				if (st.out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hw/rtl/mks_dp.sv -----
`timescale 1ns / 1ps

module mks_dp #(
	parameter int MAX_CODE_ELEMENTS = 7,
	parameter int TICK_BITS         = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mks_pkg::cmd_t              cmd,
	output mks_pkg::st_t               st,
	input  logic [mks_pkg::CHAR_W-1:0] character,
	input  logic                       message_end,
	input  logic [mks_pkg::TICK_W-1:0] dot_ticks,
	input  logic [mks_pkg::TICK_W-1:0] spacing_dot_ticks,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic                       level,
	output logic [mks_pkg::DUR_W-1:0]  duration,
	output logic                       last
);
	import mks_pkg::*;

	localparam int EFF_BITS = (TICK_BITS < TICK_W) ? TICK_BITS : TICK_W;
	localparam logic [LEN_W-1:0] MAX_LEN =
		LEN_W'((MAX_CODE_ELEMENTS > CODE_W) ? CODE_W : MAX_CODE_ELEMENTS);

	code_t             code;
	logic              is_word;
	logic [LEN_W-1:0]  lim_len;
	logic [LEN_W-1:0]  lsh;
	logic              prev_q;
	logic              out_valid_q;
	logic              word_q;
	logic              pre_q;
	logic              end_q;
	logic [CODE_W-1:0] pat_q;
	logic [LEN_W-1:0]  rem_q;
	logic              level_q;
	logic [DUR_W-1:0]  dur_q;
	logic              last_q;
	logic [TICK_W-1:0] sel_ticks;
	logic [EFF_BITS-1:0] tick_raw;
	logic [EFF_BITS-1:0] tick_eff;
	logic [DUR_W-1:0]  dur_d;

	assign code    = mks_rom(character);
	assign is_word = (character == CH_SPACE) || (character == CH_NEWLINE);
	assign lim_len = (code.len > MAX_LEN) ? MAX_LEN : code.len;
	assign lsh     = LEN_W'(CODE_W) - code.len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				prev_q <= !is_word && !message_end;
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			word_q <= is_word;
			pre_q  <= prev_q;
			end_q  <= message_end;
			pat_q  <= code.pat << lsh;
			rem_q  <= lim_len;
		end else if (cmd.advance) begin
			pat_q <= pat_q << 1;
			rem_q <= rem_q - LEN_W'(1);
		end
		if (cmd.load) begin
			level_q <= cmd.level;
			dur_q   <= dur_d;
			last_q  <= cmd.last;
		end
	end

	assign sel_ticks = cmd.spacing ? spacing_dot_ticks : dot_ticks;
	assign tick_raw  = sel_ticks[EFF_BITS-1:0];
	assign tick_eff  = (tick_raw == '0) ? EFF_BITS'(1) : tick_raw;
	assign dur_d     = DUR_W'(DUR_W'(cmd.units) * DUR_W'(tick_eff));

	assign st.word       = word_q;
	assign st.pre        = pre_q;
	assign st.has_elem   = (rem_q != '0);
	assign st.final_elem = (rem_q == LEN_W'(1));
	assign st.dash       = pat_q[CODE_W-1];
	assign st.msg_end    = end_q;
	assign st.out_free   = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign level    = level_q;
	assign duration = dur_q;
	assign last     = last_q;

endmodule

// ----- hw/rtl/morse_keyer_segments.sv -----
`timescale 1ns / 1ps
// Flow: a byte is taken in ST_IDLE, decoded in ST_DECODE, and its first segment is loaded
// into the output register once that register is free, which raises m_tvalid; then one
// segment per cycle while m_tready is high.
// Bytes: each gives 0 to 15 segments, and the next byte is taken only once the controller has
// issued the last of them into the single output register.
// Reset: arst_n clears the controller, output valid and previous-letter flag at once,
// and sets both tick registers to 1000.

module morse_keyer_segments #(
	parameter int MAX_CODE_ELEMENTS = 7,
	parameter int TICK_BITS         = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,  // [7:0] character
	input  logic                        s_tlast,  // message_end
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [31:0]                 m_tdata,  // [26:0] duration, [31:27] zero
	output logic                        m_tuser,  // [0] level
	output logic                        m_tlast,  // last
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mks_pkg::ADDR_W-1:0]  paddr,
	input  logic [mks_pkg::DATA_W-1:0]  pwdata,
	output logic [mks_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import mks_pkg::*;

	cmd_t              cmd;
	st_t               st;
	logic [TICK_W-1:0] dot_ticks;
	logic [TICK_W-1:0] spacing_dot_ticks;
	logic [DUR_W-1:0]  duration;

	mks_regs u_regs (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.dot_ticks         (dot_ticks),
		.spacing_dot_ticks (spacing_dot_ticks)
	);

	mks_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	mks_dp #(
		.MAX_CODE_ELEMENTS (MAX_CODE_ELEMENTS),
		.TICK_BITS         (TICK_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.st                (st),
		.character         (s_tdata),
		.message_end       (s_tlast),
		.dot_ticks         (dot_ticks),
		.spacing_dot_ticks (spacing_dot_ticks),
		.m_tvalid          (m_tvalid),
		.m_tready          (m_tready),
		.level             (m_tuser),
		.duration          (duration),
		.last              (m_tlast)
	);

	assign m_tdata = 32'(duration);

endmodule

// ----- hw/rtl/mks_checker.sv -----
`timescale 1ns / 1ps

module mks_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output changed while stalled");

	a_dur_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[26:0] != 27'd0) && (m_tdata[31:27] == 5'd0))
		else $error("segment duration out of range");

	a_on_then_off: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tuser && !m_tlast |=> !(m_tvalid && m_tuser))
		else $error("two key-on segments without a gap");

	a_busy_mid_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("new byte taken before its predecessor finished");

	a_decode_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("byte taken in back-to-back cycles");

endmodule

bind morse_keyer_segments mks_checker u_mks_checker (.*);
